/* hdl/tcde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcde_pkg
// Shared types, codes and glyph helpers for the text cell drawing engine.
// ----------------------------------------------------------------------------
package tcde_pkg;

    // signed working width for coordinates, ends and runs
    localparam int SW = 14;
    localparam int GW = 8;

    localparam logic [GW-1:0] SPACE_CODE = 8'h20;

    // configuration register indexes
    localparam logic [1:0] CFG_COLS    = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_OVERLAY = 2'd2;

    typedef enum logic [2:0] {
        K_CLEAR   = 3'd0,
        K_PUT     = 3'd1,
        K_HLINE   = 3'd2,
        K_VLINE   = 3'd3,
        K_OUTLINE = 3'd4,
        K_FILL    = 3'd5,
        K_READ    = 3'd6
    } t_kind;

    typedef logic signed [SW-1:0] t_sval;

    // one line segment before clipping
    typedef struct packed {
        logic  horiz;
        t_sval fixed;
        t_sval start;
        t_sval len;
    } t_seg;

    // clipped segment
    typedef struct packed {
        logic  has;
        logic  horiz;
        t_sval fixed;
        t_sval lo;
        t_sval run;
    } t_clip;

    // box pieces of an outline
    typedef struct packed {
        logic [GW-1:0] tl;
        logic [GW-1:0] tr;
        logic [GW-1:0] bl;
        logic [GW-1:0] br;
        logic [GW-1:0] hz;
        logic [GW-1:0] vt;
    } t_box;

    localparam logic [GW-1:0] G_SV_SH = 8'hC5;
    localparam logic [GW-1:0] G_V1    = 8'hB3;
    localparam logic [GW-1:0] G_H1    = 8'hC4;
    localparam logic [GW-1:0] G_DV_DH = 8'hCE;
    localparam logic [GW-1:0] G_V2    = 8'hBA;
    localparam logic [GW-1:0] G_H2    = 8'hCD;
    localparam logic [GW-1:0] G_DV_SH = 8'hD7;
    localparam logic [GW-1:0] G_SV_DH = 8'hD8;

    // merge a new glyph with the old one through the union pairs
    function automatic logic [GW-1:0] merge_glyph(input logic [GW-1:0] nw,
                                                  input logic [GW-1:0] old);
        logic [GW-1:0] res;
        res = nw;
        if ((nw == G_V1 && old == G_H1) || (nw == G_H1 && old == G_V1))
            res = G_SV_SH;
        else if ((nw == G_V2 && old == G_H2) || (nw == G_H2 && old == G_V2))
            res = G_DV_DH;
        else if ((nw == G_V2 && old == G_H1) || (nw == G_H1 && old == G_V2))
            res = G_DV_SH;
        else if ((nw == G_V1 && old == G_H2) || (nw == G_H2 && old == G_V1))
            res = G_SV_DH;
        return res;
    endfunction

    // expand a selector glyph into corners and edges
    function automatic t_box box_set(input logic [GW-1:0] g);
        t_box b;
        b = '{tl: g, tr: g, bl: g, br: g, hz: g, vt: g};
        case (g)
            G_SV_SH: b = '{tl: 8'hDA, tr: 8'hBF, bl: 8'hC0, br: 8'hD9,
                           hz: G_H1, vt: G_V1};
            G_DV_DH: b = '{tl: 8'hC9, tr: 8'hBB, bl: 8'hC8, br: 8'hBC,
                           hz: G_H2, vt: G_V2};
            G_SV_DH: b = '{tl: 8'hD5, tr: 8'hB8, bl: 8'hD4, br: 8'hBE,
                           hz: G_H2, vt: G_V1};
            G_DV_SH: b = '{tl: 8'hD6, tr: 8'hB7, bl: 8'hD3, br: 8'hBD,
                           hz: G_H1, vt: G_V2};
            default: b = '{tl: g, tr: g, bl: g, br: g, hz: g, vt: g};
        endcase
        return b;
    endfunction

endpackage

/* hdl/tcde_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcde_cmd_if
// Command channel: one drawing command per beat.
// ----------------------------------------------------------------------------
interface tcde_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [11:0] span_x;
    logic signed [11:0] span_y;
    logic [7:0]         glyph;

    modport source (output valid, kind, pos_x, pos_y, span_x, span_y, glyph,
                    input ready);
    modport sink   (input valid, kind, pos_x, pos_y, span_x, span_y, glyph,
                    output ready);
endinterface

/* hdl/tcde_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcde_res_if
// Result channel: one result per command beat.
// ----------------------------------------------------------------------------
interface tcde_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_glyph;
    logic [13:0] cells_written;

    modport source (output valid, read_glyph, cells_written, input ready);
    modport sink   (input valid, read_glyph, cells_written, output ready);
endinterface

/* hdl/tcde_seg_clip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcde_seg_clip
// Clip one horizontal or vertical segment to the active grid.
// ----------------------------------------------------------------------------
module tcde_seg_clip (
    input  tcde_pkg::t_seg  i_seg,
    input  tcde_pkg::t_sval i_cols,
    input  tcde_pkg::t_sval i_rows,
    output tcde_pkg::t_clip o_clip
);
    tcde_pkg::t_sval lim_fixed;
    tcde_pkg::t_sval lim_run;
    tcde_pkg::t_sval lo;
    tcde_pkg::t_sval hi_raw;
    tcde_pkg::t_sval hi;
    logic            ok;

    // pick limits by direction, then bound both ends
    always_comb begin
        lim_fixed = i_seg.horiz ? i_rows : i_cols;
        lim_run   = i_seg.horiz ? i_cols : i_rows;
        ok        = (i_seg.len > 0) && (i_seg.fixed >= 0) && (i_seg.fixed < lim_fixed);
        lo        = (i_seg.start < 0) ? '0 : i_seg.start;
        hi_raw    = i_seg.start + i_seg.len;
        hi        = (hi_raw > lim_run) ? lim_run : hi_raw;
        o_clip.has   = ok && (hi > lo);
        o_clip.horiz = i_seg.horiz;
        o_clip.fixed = i_seg.fixed;
        o_clip.lo    = lo;
        o_clip.run   = hi - lo;
    end
endmodule

/* hdl/text_cell_drawing_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_drawing_engine_core
// Character-cell grid held in one single-port memory; draws lines, outlines
// and filled rectangles cell by cell, with optional read-merge-write overlay.
// ----------------------------------------------------------------------------
// Read: decode, address, store read, output, finish; off the grid, a space goes
// straight to finish. Put/line/rectangle: decode, then per segment a clip and an
// address setup (skipped when clipped away) and a write per cell (overlay on:
// read, merged write), then finish; outline has 8 segments, filled rectangle one
// per clipped row plus a last check. Clear sweeps the store. One command at a
// time, the next taken the cycle after its result loads. Reset sweeps in spaces.
module text_cell_drawing_engine_core #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    tcde_cmd_if.sink    i_cmd,
    tcde_res_if.source  o_res
);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = tcde_pkg::SW;
    localparam int GW    = tcde_pkg::GW;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SWEEP, S_SEG, S_ADDR, S_CELL, S_MERGE,
        S_READ, S_RDOUT, S_DONE
    } t_state;

    // configuration
    logic [7:0] r_grid_cols;
    logic [6:0] r_grid_rows;
    logic       r_overlay;

    // command registers
    t_state              r_state;
    tcde_pkg::t_kind     r_kind;
    tcde_pkg::t_sval     r_px, r_py, r_sx, r_sy;
    logic [GW-1:0]       r_glyph;
    logic [2:0]          r_seg;
    tcde_pkg::t_sval     r_row, r_row_end;
    logic                r_horiz;
    tcde_pkg::t_sval     r_fixed, r_lo, r_run;
    logic [GW-1:0]       r_gly;
    logic [AW-1:0]       r_addr;
    logic [GW-1:0]       r_fill;
    logic                r_sweep_cmd;
    logic [13:0]         r_count;
    logic [GW-1:0]       r_res_glyph;
    logic                r_out_valid;
    logic [GW-1:0]       r_out_glyph;
    logic [13:0]         r_out_count;

    // memory
    logic [GW-1:0]       mem [DEPTH];
    logic [GW-1:0]       r_rdata;
    logic                mem_we;
    logic [GW-1:0]       mem_wdata;

    tcde_pkg::t_sval     eff_cols, eff_rows;
    tcde_pkg::t_seg      seg;
    tcde_pkg::t_clip     clip;
    tcde_pkg::t_box      box;
    tcde_pkg::t_sval     x1, y1;
    logic                seg_last;
    logic                accept;
    logic [GW-1:0]       merged;
    logic [2*SW-1:0]     area;
    logic [31:0]         addr_full;
    logic [AW-1:0]       step;
    logic [GW-1:0]       gly_sel;

    assign accept = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.read_glyph = r_out_glyph;
    assign o_res.cells_written = r_out_count;

    // saturate the grid size to the store
    always_comb begin
        eff_cols = (SW'(r_grid_cols) > SW'(MAX_COLS)) ? SW'(MAX_COLS) : SW'(r_grid_cols);
        eff_rows = (SW'(r_grid_rows) > SW'(MAX_ROWS)) ? SW'(MAX_ROWS) : SW'(r_grid_rows);
        area     = (2*SW)'($unsigned(eff_cols)) * (2*SW)'($unsigned(eff_rows));
    end

    // build the current segment
    always_comb begin
        box = tcde_pkg::box_set(r_glyph);
        x1  = r_px + r_sx - SW'(1);
        y1  = r_py + r_sy - SW'(1);
        seg = '{horiz: 1'b1, fixed: '0, start: '0, len: '0};
        gly_sel = r_glyph;
        case (r_kind)
            tcde_pkg::K_PUT:   seg = '{horiz: 1'b1, fixed: r_py, start: r_px, len: SW'(1)};
            tcde_pkg::K_HLINE: seg = '{horiz: 1'b1, fixed: r_py, start: r_px, len: r_sx};
            tcde_pkg::K_VLINE: seg = '{horiz: 1'b0, fixed: r_px, start: r_py, len: r_sx};
            tcde_pkg::K_FILL:  seg = '{horiz: 1'b1, fixed: r_row, start: r_px, len: r_sx};
            tcde_pkg::K_OUTLINE: begin
                case (r_seg)
                    3'd0: begin
                        seg = '{horiz: 1'b1, fixed: r_py, start: r_px + SW'(1),
                                len: r_sx - SW'(2)};
                        gly_sel = box.hz;
                    end
                    3'd1: begin
                        seg = '{horiz: 1'b1, fixed: y1, start: r_px + SW'(1),
                                len: r_sx - SW'(2)};
                        gly_sel = box.hz;
                    end
                    3'd2: begin
                        seg = '{horiz: 1'b0, fixed: r_px, start: r_py + SW'(1),
                                len: r_sy - SW'(2)};
                        gly_sel = box.vt;
                    end
                    3'd3: begin
                        seg = '{horiz: 1'b0, fixed: x1, start: r_py + SW'(1),
                                len: r_sy - SW'(2)};
                        gly_sel = box.vt;
                    end
                    3'd4: begin
                        seg = '{horiz: 1'b1, fixed: r_py, start: r_px, len: SW'(1)};
                        gly_sel = box.tl;
                    end
                    3'd5: begin
                        seg = '{horiz: 1'b1, fixed: r_py, start: x1, len: SW'(1)};
                        gly_sel = box.tr;
                    end
                    3'd6: begin
                        seg = '{horiz: 1'b1, fixed: y1, start: r_px, len: SW'(1)};
                        gly_sel = box.bl;
                    end
                    default: begin
                        seg = '{horiz: 1'b1, fixed: y1, start: x1, len: SW'(1)};
                        gly_sel = box.br;
                    end
                endcase
            end
            default: seg = '{horiz: 1'b1, fixed: '0, start: '0, len: '0};
        endcase
        case (r_kind)
            tcde_pkg::K_OUTLINE: seg_last = (r_seg == 3'd7);
            tcde_pkg::K_FILL:    seg_last = 1'b0;
            default:             seg_last = 1'b1;
        endcase
    end

    tcde_seg_clip u_clip (
        .i_seg  (seg),
        .i_cols (eff_cols),
        .i_rows (eff_rows),
        .o_clip (clip)
    );

    // cell address from the clipped start, and the walk step
    always_comb begin
        if (r_horiz)
            addr_full = 32'($unsigned(r_fixed)) * 32'(MAX_COLS) + 32'($unsigned(r_lo));
        else
            addr_full = 32'($unsigned(r_lo)) * 32'(MAX_COLS) + 32'($unsigned(r_fixed));
        step   = r_horiz ? AW'(1) : AW'(MAX_COLS);
        merged = tcde_pkg::merge_glyph(r_gly, r_rdata);
    end

    // memory write select
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_gly;
        case (r_state)
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_wdata = r_fill;
            end
            S_CELL: begin
                mem_we    = !r_overlay;
                mem_wdata = r_gly;
            end
            S_MERGE: begin
                mem_we    = 1'b1;
                mem_wdata = merged;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // store: one write and one registered read, both at the walk address
    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[r_addr] <= mem_wdata;
        r_rdata <= mem[r_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= 8'd80;
            r_grid_rows <= 7'd25;
            r_overlay   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcde_pkg::CFG_COLS:    r_grid_cols <= i_cfg_data;
                tcde_pkg::CFG_ROWS:    r_grid_rows <= i_cfg_data[6:0];
                tcde_pkg::CFG_OVERLAY: r_overlay   <= i_cfg_data[0];
                default:               r_overlay   <= r_overlay;
            endcase
        end
    end

    // command sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_addr      <= '0;
            r_fill      <= tcde_pkg::SPACE_CODE;
            r_sweep_cmd <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_res_glyph <= '0;
            r_seg       <= '0;
        end else begin
            // drop the result beat once taken, unless a new one loads now
            if (o_res.ready && r_state != S_DONE)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind      <= tcde_pkg::t_kind'(i_cmd.kind);
                        r_px        <= SW'(i_cmd.pos_x);
                        r_py        <= SW'(i_cmd.pos_y);
                        r_sx        <= SW'(i_cmd.span_x);
                        r_sy        <= SW'(i_cmd.span_y);
                        r_glyph     <= i_cmd.glyph;
                        r_count     <= '0;
                        r_res_glyph <= '0;
                        r_seg       <= '0;
                        r_state     <= S_START;
                    end
                end
                S_START: begin
                    r_row     <= (r_py < 0) ? '0 : r_py;
                    r_row_end <= ((r_py + r_sy) > eff_rows) ? eff_rows : (r_py + r_sy);
                    case (r_kind)
                        tcde_pkg::K_CLEAR: begin
                            r_fill      <= r_glyph;
                            r_addr      <= '0;
                            r_sweep_cmd <= 1'b1;
                            r_state     <= S_SWEEP;
                        end
                        tcde_pkg::K_READ: begin
                            r_horiz <= 1'b1;
                            r_fixed <= r_py;
                            r_lo    <= r_px;
                            if (r_px >= 0 && r_px < eff_cols && r_py >= 0 && r_py < eff_rows)
                                r_state <= S_ADDR;
                            else begin
                                r_res_glyph <= tcde_pkg::SPACE_CODE;
                                r_state     <= S_DONE;
                            end
                        end
                        tcde_pkg::K_PUT, tcde_pkg::K_HLINE, tcde_pkg::K_VLINE:
                            r_state <= S_SEG;
                        tcde_pkg::K_OUTLINE, tcde_pkg::K_FILL:
                            r_state <= (r_sx > 0 && r_sy > 0) ? S_SEG : S_DONE;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_SWEEP: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(DEPTH - 1)) begin
                        r_count     <= area[13:0];
                        r_sweep_cmd <= 1'b0;
                        r_state     <= r_sweep_cmd ? S_DONE : S_IDLE;
                    end
                end
                S_SEG: begin
                    if (r_kind == tcde_pkg::K_FILL && r_row >= r_row_end)
                        r_state <= S_DONE;
                    else if (clip.has) begin
                        r_horiz <= clip.horiz;
                        r_fixed <= clip.fixed;
                        r_lo    <= clip.lo;
                        r_run   <= clip.run;
                        r_gly   <= gly_sel;
                        r_state <= S_ADDR;
                    end else begin
                        r_seg   <= r_seg + 3'd1;
                        r_row   <= r_row + SW'(1);
                        r_state <= seg_last ? S_DONE : S_SEG;
                    end
                end
                S_ADDR: begin
                    r_addr  <= addr_full[AW-1:0];
                    r_state <= (r_kind == tcde_pkg::K_READ) ? S_READ
                                                            : S_CELL;
                end
                S_CELL, S_MERGE: begin
                    if (r_state == S_CELL && r_overlay)
                        r_state <= S_MERGE;
                    else begin
                        r_count <= r_count + 14'd1;
                        r_run   <= r_run - SW'(1);
                        r_addr  <= r_addr + step;
                        if (r_run == SW'(1)) begin
                            r_seg   <= r_seg + 3'd1;
                            r_row   <= r_row + SW'(1);
                            r_state <= seg_last ? S_DONE : S_SEG;
                        end else
                            r_state <= S_CELL;
                    end
                end
                S_READ: r_state <= S_RDOUT;
                S_RDOUT: begin
                    r_res_glyph <= r_rdata;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_glyph <= r_res_glyph;
                        r_out_count <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a walk never starts with an empty run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> (r_run > 0))
        else $error("cell walk with empty run");

    // an accepted command always starts decoding next
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_START))
        else $error("accepted command not decoded");

    // cell writes stay inside the store
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL || r_state == S_MERGE) |-> (r_addr <= AW'(DEPTH - 1)))
        else $error("cell address outside store");

    // a result is only loaded from the finishing state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside finish");
endmodule
